### hw/rtl/icanon_pkg.sv
// Package for the identifier canonicalizer: shared types, character codes,
// verdict codes and small character-class functions.
// No dependencies; every other file of the block imports it.
package icanon_pkg;

    // Raw byte limit used when the top level is not given another value.
    localparam int unsigned MAX_RAW_BYTES_DEF = 4096;

    // Canonical length counter saturates at 8192, so it needs 14 bits.
    localparam int CANON_W = 14;
    localparam logic [CANON_W-1:0] CANON_SAT = 14'd8192;

    // Configuration register: largest allowed canonical length.
    localparam int CFG_W = 13;
    localparam logic [CFG_W-1:0] CFG_RESET = 13'd255;

    // Character codes that the rules single out.
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CASE_BIT = 8'h20;

    // Verdict status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_LIMIT     = 2'd2
    } t_status;

    // Failure reasons in priority order.
    typedef enum logic [3:0] {
        FR_NONE        = 4'd0,
        FR_EMPTY       = 4'd1,
        FR_RAW_LONG    = 4'd2,
        FR_UNPRINTABLE = 4'd3,
        FR_BLANK       = 4'd4,
        FR_ONLY_SLASH  = 4'd5,
        FR_CANON_LONG  = 4'd6,
        FR_BAD_START   = 4'd7,
        FR_BAD_CHAR    = 4'd8,
        FR_EMPTY_SEG   = 4'd9,
        FR_TRAIL_SEP   = 4'd10
    } t_reason;

    // First error found in the body of the identifier.
    typedef enum logic [1:0] {
        BE_NONE      = 2'd0,
        BE_BAD_CHAR  = 2'd1,
        BE_EMPTY_SEG = 2'd2
    } t_body_err;

    // One input transaction.
    typedef struct packed {
        logic [7:0] raw_byte;
        logic       end_of_id;
        logic       no_byte;
    } t_in_item;

    // One result transaction.
    typedef struct packed {
        logic [7:0] canon_byte;
        logic       canon_valid;
        logic       verdict_ready;
        logic [1:0] status;
        logic [3:0] fail_reason;
    } t_out_item;

    // UTF-8 checker status after the current byte.
    typedef struct packed {
        logic bad;
        logic pending;
    } t_utf8_stat;

    // ASCII whitespace: space, tab, line feed, vertical tab, form feed, return.
    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    // Lower case letter or decimal digit.
    function automatic logic is_lalnum(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h30 && c <= 8'h39);
    endfunction

    // Segment separator.
    function automatic logic is_sep(input logic [7:0] c);
        return (c == CH_DOT) || (c == CH_UNDER) || (c == CH_COLON) || (c == CH_DASH);
    endfunction

endpackage

### hw/rtl/icanon_if.sv
// Channel interfaces of the identifier canonicalizer: byte input, result
// output and configuration write. Each carries valid, ready and a payload.
// Depends on icanon_pkg.
interface icanon_in_if;
    import icanon_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface icanon_out_if;
    import icanon_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface icanon_cfg_if;
    import icanon_pkg::*;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/icanon_utf8.sv
// Strict UTF-8 well-formedness tracker with control byte detection.
// Reports the status after the current byte. Depends on icanon_pkg.
module icanon_utf8 (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_clr,
    input  logic [7:0]             i_byte,
    output icanon_pkg::t_utf8_stat o_stat
);
    import icanon_pkg::*;

    logic [1:0] r_pending, n_pending;
    logic [7:0] r_lo, n_lo;
    logic [7:0] r_hi, n_hi;
    logic       r_bad, n_bad;

    // Next state for one byte: continuation range check or lead byte decode.
    always_comb begin
        n_pending = r_pending;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_bad     = r_bad;
        if (i_en) begin
            if (r_pending != 2'd0) begin
                if (i_byte < r_lo || i_byte > r_hi) begin
                    n_bad     = 1'b1;
                    n_pending = 2'd0;
                end else begin
                    n_pending = r_pending - 2'd1;
                    n_lo      = 8'h80;
                    n_hi      = 8'hBF;
                end
            end else begin
                n_lo = 8'h80;
                n_hi = 8'hBF;
                if (i_byte < 8'h80) begin
                    if ((i_byte < 8'h20 && !is_ws(i_byte)) || i_byte == 8'h7F) begin
                        n_bad = 1'b1;
                    end
                end else if (i_byte >= 8'hC2 && i_byte <= 8'hDF) begin
                    n_pending = 2'd1;
                end else if (i_byte >= 8'hE0 && i_byte <= 8'hEF) begin
                    n_pending = 2'd2;
                    if (i_byte == 8'hE0) n_lo = 8'hA0;
                    if (i_byte == 8'hED) n_hi = 8'h9F;
                end else if (i_byte >= 8'hF0 && i_byte <= 8'hF4) begin
                    n_pending = 2'd3;
                    if (i_byte == 8'hF0) n_lo = 8'h90;
                    if (i_byte == 8'hF4) n_hi = 8'h8F;
                end else begin
                    n_bad = 1'b1;
                end
            end
        end
    end

    // Status seen by the verdict logic for this transaction.
    assign o_stat.bad     = n_bad;
    assign o_stat.pending = (n_pending != 2'd0);

    // State is cleared at reset and once an identifier is finished.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_pending <= 2'd0;
            r_lo      <= 8'h00;
            r_hi      <= 8'h00;
            r_bad     <= 1'b0;
        end else begin
            r_pending <= n_pending;
            r_lo      <= n_lo;
            r_hi      <= n_hi;
            r_bad     <= n_bad;
        end
    end

endmodule

### hw/rtl/icanon_track.sv
// Per-identifier tracking: trim phase, counters, segment rules, byte mapping
// and the final verdict. Produces the result for the accepted transaction.
// Depends on icanon_pkg.
module icanon_track #(
    parameter int unsigned MAX_RAW_BYTES = icanon_pkg::MAX_RAW_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  icanon_pkg::t_in_item          i_item,
    input  icanon_pkg::t_utf8_stat        i_utf8,
    input  logic [icanon_pkg::CFG_W-1:0]  i_max_len,
    output icanon_pkg::t_out_item         o_result
);
    import icanon_pkg::*;

    // Raw counter saturates at MAX_RAW_BYTES + 1.
    localparam int RAW_W = $clog2(MAX_RAW_BYTES + 2);
    localparam logic [RAW_W-1:0] RAW_LIMIT = RAW_W'(MAX_RAW_BYTES);

    logic               r_body, n_body;
    logic [RAW_W-1:0]   r_raw_cnt, n_raw_cnt;
    logic [CANON_W-1:0] r_canon_cnt, n_canon_cnt;
    logic [CANON_W-1:0] r_space_run, n_space_run;
    logic               r_last_sep, n_last_sep;
    logic               r_first_err, n_first_err;
    t_body_err          r_body_err, n_body_err;

    logic               has_byte;
    logic               finish;
    logic [7:0]         mapped;
    logic               emit;
    logic [CANON_W:0]   canon_sum;
    t_body_err          body_err_mid;
    t_reason            reason;
    t_status            status;

    assign has_byte = i_accept && !i_item.no_byte;
    assign finish   = i_accept && i_item.end_of_id;

    // Byte mapping: slash becomes dot, upper case folds to lower case.
    always_comb begin
        if (i_item.raw_byte == CH_SLASH) begin
            mapped = CH_DOT;
        end else if (i_item.raw_byte >= CH_UP_A && i_item.raw_byte <= CH_UP_Z) begin
            mapped = i_item.raw_byte | CASE_BIT;
        end else begin
            mapped = i_item.raw_byte;
        end
    end

    assign canon_sum = {1'b0, r_canon_cnt} + {1'b0, r_space_run} + {{CANON_W{1'b0}}, 1'b1};

    // Trimming, counting and commit of one canonical byte.
    always_comb begin
        n_body       = r_body;
        n_raw_cnt    = r_raw_cnt;
        n_canon_cnt  = r_canon_cnt;
        n_space_run  = r_space_run;
        n_last_sep   = r_last_sep;
        n_first_err  = r_first_err;
        n_body_err   = r_body_err;
        emit         = 1'b0;
        body_err_mid = r_body_err;
        if (has_byte) begin
            if (r_raw_cnt <= RAW_LIMIT) n_raw_cnt = r_raw_cnt + 1'b1;
            if (!r_body) begin
                if (!is_ws(i_item.raw_byte)) begin
                    n_body = 1'b1;
                    emit   = (i_item.raw_byte != CH_SLASH);
                end
            end else if (is_ws(i_item.raw_byte)) begin
                if (r_space_run != CANON_SAT) n_space_run = r_space_run + 1'b1;
            end else begin
                emit = 1'b1;
            end
        end
        if (emit) begin
            // Pending inner whitespace turns into unsupported characters.
            if (r_canon_cnt == '0 && (r_space_run != '0 || !is_lalnum(mapped))) begin
                n_first_err = 1'b1;
            end
            if (r_space_run != '0 && r_body_err == BE_NONE) body_err_mid = BE_BAD_CHAR;
            if (body_err_mid == BE_NONE) begin
                if (is_lalnum(mapped)) begin
                    n_last_sep = 1'b0;
                end else if (!is_sep(mapped)) begin
                    body_err_mid = BE_BAD_CHAR;
                end else if (r_last_sep) begin
                    body_err_mid = BE_EMPTY_SEG;
                end else begin
                    n_last_sep = 1'b1;
                end
            end
            n_body_err  = body_err_mid;
            n_canon_cnt = (canon_sum > {1'b0, CANON_SAT}) ? CANON_SAT : canon_sum[CANON_W-1:0];
            n_space_run = '0;
        end
    end

    // Verdict in priority order, taken from the state after this byte.
    always_comb begin
        reason = FR_NONE;
        if (n_raw_cnt == '0) begin
            reason = FR_EMPTY;
        end else if (n_raw_cnt > RAW_LIMIT) begin
            reason = FR_RAW_LONG;
        end else if (i_utf8.bad || i_utf8.pending) begin
            reason = FR_UNPRINTABLE;
        end else if (!n_body) begin
            reason = FR_BLANK;
        end else if (n_canon_cnt == '0) begin
            reason = FR_ONLY_SLASH;
        end else if (n_canon_cnt > {1'b0, i_max_len}) begin
            reason = FR_CANON_LONG;
        end else if (n_first_err) begin
            reason = FR_BAD_START;
        end else if (n_body_err == BE_BAD_CHAR) begin
            reason = FR_BAD_CHAR;
        end else if (n_body_err == BE_EMPTY_SEG) begin
            reason = FR_EMPTY_SEG;
        end else if (n_last_sep) begin
            reason = FR_TRAIL_SEP;
        end
        if (reason == FR_NONE) begin
            status = ST_OK;
        end else if (reason == FR_RAW_LONG || reason == FR_CANON_LONG) begin
            status = ST_LIMIT;
        end else begin
            status = ST_MALFORMED;
        end
    end

    // Result for the accepted transaction.
    assign o_result.canon_byte    = emit ? mapped : 8'h00;
    assign o_result.canon_valid   = emit;
    assign o_result.verdict_ready = i_item.end_of_id;
    assign o_result.status        = i_item.end_of_id ? status : ST_OK;
    assign o_result.fail_reason   = i_item.end_of_id ? reason : FR_NONE;

    // State registers; a finished identifier starts the next one clean.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || finish) begin
            r_body      <= 1'b0;
            r_raw_cnt   <= '0;
            r_canon_cnt <= '0;
            r_space_run <= '0;
            r_last_sep  <= 1'b0;
            r_first_err <= 1'b0;
            r_body_err  <= BE_NONE;
        end else begin
            r_body      <= n_body;
            r_raw_cnt   <= n_raw_cnt;
            r_canon_cnt <= n_canon_cnt;
            r_space_run <= n_space_run;
            r_last_sep  <= n_last_sep;
            r_first_err <= n_first_err;
            r_body_err  <= n_body_err;
        end
    end

endmodule

### hw/rtl/icanon_obuf.sv
// Result buffer: an output register backed by one skid entry, so the input
// side can take one more result while the output is stalled. Depends on icanon_pkg.
module icanon_obuf (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  icanon_pkg::t_out_item i_data,
    output logic                  o_ready,
    output logic                  o_valid,
    output icanon_pkg::t_out_item o_data,
    input  logic                  i_out_ready
);
    import icanon_pkg::*;

    logic      r_main_valid;
    t_out_item r_main;
    logic      r_skid_valid;
    t_out_item r_skid;
    logic      pop;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;
    assign pop     = r_main_valid && i_out_ready;

    // Control: main register drains first, skid refills it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_valid;
            end
        end else if (!r_main_valid) begin
            r_main_valid <= i_valid;
        end else if (i_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload: no reset needed.
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_main <= r_skid_valid ? r_skid : i_data;
        end else if (!r_main_valid) begin
            r_main <= i_data;
        end else if (i_valid && !r_skid_valid) begin
            r_skid <= i_data;
        end
    end

endmodule

### hw/rtl/identifier_canonicalizer_top.sv
// Identifier canonicalizer, top level: configuration register, UTF-8 checker,
// identifier tracker and result buffer. Depends on icanon_pkg, icanon_if,
// icanon_utf8, icanon_track and icanon_obuf.
//
// The block takes one raw identifier byte per transaction and returns exactly
// one result per transaction, registered in the result buffer. A new byte can
// be accepted every cycle while the skid entry is free; the whole per-byte update
// (trim state, counters, UTF-8 check, verdict) is one level of logic in front
// of the result register. A one-entry skid stage behind it lets the input take
// one more transaction while a result waits; input ready drops only when both
// entries are full. The configuration channel is always ready; the user must
// write the length limit only while no identifier is in progress (not enforced).
module identifier_canonicalizer_top #(
    parameter int unsigned MAX_RAW_BYTES = icanon_pkg::MAX_RAW_BYTES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    icanon_in_if.sink    i_in,
    icanon_out_if.source o_out,
    icanon_cfg_if.sink   i_cfg
);
    import icanon_pkg::*;

    logic             r_max_len;
    logic [CFG_W-1:0] r_max_len_q;
    logic             accept;
    logic             in_ready;
    t_utf8_stat       utf8_stat;
    t_out_item        result;
    logic             out_valid;
    t_out_item        out_data;

    assign accept      = i_in.valid && in_ready;
    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = out_valid;
    assign o_out.data  = out_data;

    // Configuration register: canonical length limit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len_q <= CFG_RESET;
            r_max_len   <= 1'b0;
        end else if (i_cfg.valid) begin
            r_max_len_q <= i_cfg.data;
            r_max_len   <= 1'b1;
        end
    end

    // UTF-8 and control byte checking.
    icanon_utf8 u_utf8 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (accept && !i_in.data.no_byte),
        .i_clr   (accept && i_in.data.end_of_id),
        .i_byte  (i_in.data.raw_byte),
        .o_stat  (utf8_stat)
    );

    // Trimming, mapping, counters and verdict.
    icanon_track #(
        .MAX_RAW_BYTES (MAX_RAW_BYTES)
    ) u_track (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_item    (i_in.data),
        .i_utf8    (utf8_stat),
        .i_max_len (r_max_len_q),
        .o_result  (result)
    );

    // Result register with skid entry.
    icanon_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (accept),
        .i_data      (result),
        .o_ready     (in_ready),
        .o_valid     (out_valid),
        .o_data      (out_data),
        .i_out_ready (o_out.ready)
    );

    // A byte that is not emitted reads as zero, and verdict fields stay zero
    // on results that carry no verdict.
    a_idle_fields_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_data.verdict_ready |->
            out_data.status == ST_OK && out_data.fail_reason == FR_NONE)
        else $error("verdict fields set on a result without verdict");

    a_no_byte_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_data.canon_valid |-> out_data.canon_byte == 8'h00)
        else $error("canonical byte set without canon_valid");

    // Emitted bytes are already canonical: no slash, no upper case.
    a_byte_canonical : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_data.canon_valid |->
            out_data.canon_byte != CH_SLASH &&
            !(out_data.canon_byte >= CH_UP_A && out_data.canon_byte <= CH_UP_Z))
        else $error("non-canonical byte emitted");

    // Limit status goes with the two length reasons only.
    a_status_reason : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_data.verdict_ready && out_data.status == ST_LIMIT |->
            out_data.fail_reason == FR_RAW_LONG || out_data.fail_reason == FR_CANON_LONG)
        else $error("limit status with wrong reason");

    // An accepted final byte always leaves a result waiting in the buffer.
    a_end_reaches_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in.data.end_of_id |=> out_valid)
        else $error("final transaction produced no result");

    // The configuration channel never stalls and each write lands.
    a_cfg_written : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg.valid |=> r_max_len && r_max_len_q == $past(i_cfg.data))
        else $error("configuration write lost");

endmodule
